@@ sv/rua_pkg.sv @@
// ----------------------------------------------------------------------------
// rua_pkg
// Shared constants and types of the rectangle union area block.
// ----------------------------------------------------------------------------
`default_nettype none

package rua_pkg;

	localparam int MAX_RECTS = 8;
	localparam int IDX_W     = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
	localparam int CNT_W     = $clog2(MAX_RECTS + 1);
	localparam int CRD_W     = 10;
	localparam int EDGE_W    = CRD_W + 1;
	localparam int PROD_W    = 2 * EDGE_W;
	localparam int AREA_W    = 23;
	localparam int SUM_W     = PROD_W + MAX_RECTS + 2;

	typedef struct packed {
		logic [CRD_W-1:0] x;
		logic [CRD_W-1:0] y;
		logic [CRD_W-1:0] w;
		logic [CRD_W-1:0] h;
	} rect_t;

	// one store read during the subset walk
	typedef struct packed {
		logic vld;
		logic member;
		logic first;
		logic last;
	} walk_tag_t;

	// one finished subset, ready for the multiplier
	typedef struct packed {
		logic              vld;
		logic              ok;
		logic              neg;
		logic [EDGE_W-1:0] dx;
		logic [EDGE_W-1:0] dy;
	} term_t;

endpackage

`default_nettype wire

@@ sv/rua_in_if.sv @@
// ----------------------------------------------------------------------------
// rua_in_if
// Rectangle input channel: valid/ready handshake with one rectangle per
// transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rua_in_if import rua_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CRD_W-1:0] rect_x;
	logic [CRD_W-1:0] rect_y;
	logic [CRD_W-1:0] rect_width;
	logic [CRD_W-1:0] rect_height;
	logic             last_rect;

	modport source (
		output valid, rect_x, rect_y, rect_width, rect_height, last_rect,
		input  ready
	);
	modport sink (
		input  valid, rect_x, rect_y, rect_width, rect_height, last_rect,
		output ready
	);
endinterface

`default_nettype wire

@@ sv/rua_out_if.sv @@
// ----------------------------------------------------------------------------
// rua_out_if
// Result channel: valid/ready handshake with one union area per
// transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface rua_out_if import rua_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [AREA_W-1:0] union_area;
	logic              too_many;

	modport source (
		output valid, union_area, too_many,
		input  ready
	);
	modport sink (
		input  valid, union_area, too_many,
		output ready
	);
endinterface

`default_nettype wire

@@ sv/rect_union_area_incl_excl.sv @@
// ----------------------------------------------------------------------------
// rect_union_area_incl_excl
// Union area of a set of rectangles by inclusion-exclusion over all subsets.
// ----------------------------------------------------------------------------
// in_ch takes one rectangle per transaction (x, y, width, height, last_rect).
// Loading takes one rectangle per cycle; up to MAX_RECTS are kept in the
// store, later ones are dropped and reported through too_many.
// The transaction with last_rect set starts the subset walk. in_ch.ready is
// low during the walk. Each nonempty subset of the N stored rectangles reads
// all N entries through the single read port of the store, one per cycle.
// The result goes into an output register on out_ch, and loading of the next
// set resumes at once. If that register is still held by a stalled receiver
// when the next walk ends, the block waits there with in_ch.ready low.
// After reset the store is empty, no result is pending and in_ch.ready is
// high. A set with every rectangle dropped yields union_area 0.
// ----------------------------------------------------------------------------
`default_nettype none

module rect_union_area_incl_excl import rua_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	rua_in_if.sink    in_ch,
	rua_out_if.source out_ch
);

	localparam logic ST_LOAD = 1'b0;
	localparam logic ST_WALK = 1'b1;

	logic                 state_q;
	logic [CNT_W-1:0]     count_q;
	logic                 ovf_q;
	logic                 issue_q;
	logic [MAX_RECTS-1:0] mask_q;
	logic [IDX_W-1:0]     idx_q;
	walk_tag_t            tag_s1;
	logic                 out_vld_q;
	logic [AREA_W-1:0]    out_area_q;
	logic                 out_many_q;

	logic                 in_acc, store_wr, last_idx, last_mask, finish, acc_busy;
	logic [CNT_W-1:0]     count_nxt, nm1_w;
	logic [MAX_RECTS:0]   lim_w;
	rect_t                wr_rect, rd_rect;
	term_t                term_s2;
	logic [SUM_W-1:0]     sum_w;

	assign in_ch.ready = (state_q == ST_LOAD);
	assign in_acc      = in_ch.valid && in_ch.ready;
	assign store_wr    = in_acc && (count_q < CNT_W'(MAX_RECTS));
	assign count_nxt   = store_wr ? (count_q + 1'b1) : count_q;

	assign wr_rect.x = in_ch.rect_x;
	assign wr_rect.y = in_ch.rect_y;
	assign wr_rect.w = in_ch.rect_width;
	assign wr_rect.h = in_ch.rect_height;

	assign nm1_w     = count_q - 1'b1;
	assign lim_w     = ((MAX_RECTS + 1)'(1) << count_q) - 1'b1;
	assign last_idx  = (idx_q == nm1_w[IDX_W-1:0]);
	assign last_mask = (mask_q == lim_w[MAX_RECTS-1:0]);

	// walk is over once nothing is left in the read, fold or multiply stages and the output register is free
	assign finish = (state_q == ST_WALK) && !issue_q && !tag_s1.vld && !term_s2.vld &&
		!acc_busy && (!out_vld_q || out_ch.ready);

	rua_store u_store (
		.clk     (clk),
		.wr_en   (store_wr),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data (wr_rect),
		.rd_en   (issue_q),
		.rd_addr (idx_q),
		.rd_data (rd_rect)
	);

	rua_isect u_isect (
		.clk     (clk),
		.arst_n  (arst_n),
		.tag_s1  (tag_s1),
		.rect_s1 (rd_rect),
		.term_s2 (term_s2)
	);

	rua_acc u_acc (
		.clk     (clk),
		.arst_n  (arst_n),
		.term_s2 (term_s2),
		.clr     (finish),
		.busy    (acc_busy),
		.sum     (sum_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			issue_q   <= 1'b0;
			mask_q    <= '0;
			idx_q     <= '0;
			tag_s1    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			tag_s1.vld    <= issue_q;
			tag_s1.member <= mask_q[idx_q];
			tag_s1.first  <= (idx_q == '0);
			tag_s1.last   <= last_idx;

			if (finish) begin
				out_vld_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_vld_q <= 1'b0;
			end

			case (state_q)
				ST_LOAD: begin
					if (in_acc) begin
						count_q <= count_nxt;
						ovf_q   <= ovf_q | !store_wr;
						if (in_ch.last_rect) begin
							state_q <= ST_WALK;
							issue_q <= (count_nxt != '0);
							mask_q  <= MAX_RECTS'(1);
							idx_q   <= '0;
						end
					end
				end
				ST_WALK: begin
					if (issue_q) begin
						if (last_idx) begin
							idx_q <= '0;
							if (last_mask) begin
								issue_q <= 1'b0;
							end else begin
								mask_q <= mask_q + 1'b1;
							end
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (finish) begin
						state_q <= ST_LOAD;
						count_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (finish) begin
			out_area_q <= sum_w[SUM_W-1] ? '0 : sum_w[AREA_W-1:0];
			out_many_q <= ovf_q;
		end
	end

	assign out_ch.valid      = out_vld_q;
	assign out_ch.union_area = out_area_q;
	assign out_ch.too_many   = out_many_q;

`ifndef SYNTHESIS
	a_no_load_while_walking: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !issue_q && !tag_s1.vld)
		else $error("rectangle accepted while the subset walk is running");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_RECTS))
		else $error("rectangle count beyond store size");

	a_finish_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> out_vld_q && (state_q == ST_LOAD))
		else $error("finished walk did not present a result");

	a_acc_only_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		acc_busy |-> (state_q == ST_WALK))
		else $error("subset term accumulated outside the walk");
`endif

endmodule

`default_nettype wire

@@ sv/rua_store.sv @@
// ----------------------------------------------------------------------------
// rua_store
// Rectangle store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module rua_store import rua_pkg::*; (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire rect_t            wr_data,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output rect_t                 rd_data
);

	rect_t mem_q [MAX_RECTS];
	rect_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

@@ sv/rua_isect.sv @@
// ----------------------------------------------------------------------------
// rua_isect
// Folds the members of one subset into a running intersection and checks
// every new member against all earlier ones for strict overlap.
// ----------------------------------------------------------------------------
`default_nettype none

module rua_isect import rua_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire walk_tag_t tag_s1,
	input  wire rect_t     rect_s1,
	output term_t          term_s2
);

	logic              seen_q, ok_q, par_q;
	logic [EDGE_W-1:0] maxl_q, maxt_q, minr_q, minb_q;
	term_t             term_q;

	logic              seen0, ok0, par0;
	logic [EDGE_W-1:0] maxl0, maxt0, minr0, minb0;
	logic              seen_n, ok_n, par_n;
	logic [EDGE_W-1:0] maxl_n, maxt_n, minr_n, minb_n;
	logic [EDGE_W-1:0] x_w, y_w, r_w, b_w;
	logic              pass_w;

	always_comb begin
		x_w = {1'b0, rect_s1.x};
		y_w = {1'b0, rect_s1.y};
		r_w = x_w + {1'b0, rect_s1.w};
		b_w = y_w + {1'b0, rect_s1.h};

		if (tag_s1.first) begin
			seen0 = 1'b0;
			ok0   = 1'b1;
			par0  = 1'b0;
			maxl0 = '0;
			maxt0 = '0;
			minr0 = '1;
			minb0 = '1;
		end else begin
			seen0 = seen_q;
			ok0   = ok_q;
			par0  = par_q;
			maxl0 = maxl_q;
			maxt0 = maxt_q;
			minr0 = minr_q;
			minb0 = minb_q;
		end

		// new member against every earlier one, through the running extremes
		pass_w = !seen0 || ((x_w < minr0) && (maxl0 < r_w) &&
			(y_w < minb0) && (maxt0 < b_w));

		seen_n = seen0;
		ok_n   = ok0;
		par_n  = par0;
		maxl_n = maxl0;
		maxt_n = maxt0;
		minr_n = minr0;
		minb_n = minb0;
		if (tag_s1.member) begin
			seen_n = 1'b1;
			ok_n   = ok0 & pass_w;
			par_n  = ~par0;
			maxl_n = (x_w > maxl0) ? x_w : maxl0;
			maxt_n = (y_w > maxt0) ? y_w : maxt0;
			minr_n = (r_w < minr0) ? r_w : minr0;
			minb_n = (b_w < minb0) ? b_w : minb0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			ok_q   <= 1'b1;
			par_q  <= 1'b0;
			maxl_q <= '0;
			maxt_q <= '0;
			minr_q <= '1;
			minb_q <= '1;
			term_q <= '0;
		end else begin
			if (tag_s1.vld) begin
				seen_q <= seen_n;
				ok_q   <= ok_n;
				par_q  <= par_n;
				maxl_q <= maxl_n;
				maxt_q <= maxt_n;
				minr_q <= minr_n;
				minb_q <= minb_n;
			end
			term_q.vld <= tag_s1.vld & tag_s1.last;
			term_q.ok  <= ok_n & seen_n;
			term_q.neg <= ~par_n;
			term_q.dx  <= (minr_n > maxl_n) ? (minr_n - maxl_n) : '0;
			term_q.dy  <= (minb_n > maxt_n) ? (minb_n - maxt_n) : '0;
		end
	end

	assign term_s2 = term_q;

endmodule

`default_nettype wire

@@ sv/rua_acc.sv @@
// ----------------------------------------------------------------------------
// rua_acc
// Area multiplier and signed inclusion-exclusion accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module rua_acc import rua_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire term_t      term_s2,
	input  wire logic       clr,
	output logic            busy,
	output logic [SUM_W-1:0] sum
);

	logic              vld_s3, neg_s3;
	logic [PROD_W-1:0] prod_s3;
	logic [SUM_W-1:0]  sum_q;
	logic [PROD_W-1:0] prod_w;

	assign prod_w = PROD_W'(term_s2.dx) * PROD_W'(term_s2.dy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3  <= 1'b0;
			neg_s3  <= 1'b0;
			prod_s3 <= '0;
			sum_q   <= '0;
		end else begin
			vld_s3  <= term_s2.vld;
			neg_s3  <= term_s2.neg;
			prod_s3 <= term_s2.ok ? prod_w : '0;
			if (clr) begin
				sum_q <= '0;
			end else if (vld_s3) begin
				sum_q <= neg_s3 ? (sum_q - SUM_W'(prod_s3)) : (sum_q + SUM_W'(prod_s3));
			end
		end
	end

	assign busy = vld_s3;
	assign sum  = sum_q;

endmodule

`default_nettype wire

@@ sim/tb_rect_union_area_incl_excl.sv @@
// ----------------------------------------------------------------------------
// tb_rect_union_area_incl_excl
// Self-checking bench for the rectangle union area block. Rectangle sets are
// driven on in_ch; every accepted rectangle is noted in a scoreboard, which
// works out the union area of each finished set by inclusion-exclusion over
// all subsets. Each result on out_ch is compared with the oldest expected
// area. Random idling on both channels, a long receiver hold-off and
// drain pauses put the block through stalls in every phase of its work.
// ----------------------------------------------------------------------------
module tb_rect_union_area_incl_excl import rua_pkg::*;;

	localparam int N_ITEMS         = 2000;
	localparam int HOLD_OFF_CYCLES = 3000;
	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int DRAIN_CYCLES    = 40;
	localparam int CRD_MAX         = (1 << CRD_W) - 1;

	typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_e;

	typedef struct {
		logic [AREA_W-1:0] area;
		logic              too_many;
	} area_result_t;

	// expected areas of finished sets, plus the set being loaded
	class area_scoreboard;
		rect_t        set_rects[$];
		bit           dropped;
		area_result_t areas_due[$];
		int           errors;

		function bit strict_overlap(rect_t a, rect_t b);
			int ax, ay, bx, by;
			ax = int'(a.x);
			ay = int'(a.y);
			bx = int'(b.x);
			by = int'(b.y);
			return ax < bx + int'(b.w) && ax + int'(a.w) > bx &&
				ay < by + int'(b.h) && ay + int'(a.h) > by;
		endfunction

		function longint union_area_predict();
			longint total, left, top, right, bottom, term;
			longint xi, yi, ri, bi;
			int     n, mask, i, j, members;
			bit     apart;
			n = set_rects.size();
			total = 0;
			for (mask = 1; mask < (1 << n); mask++) begin
				members = 0;
				left = 0;
				top = 0;
				right = 64'hFFFF_FFFF;
				bottom = 64'hFFFF_FFFF;
				apart = 0;
				for (i = 0; i < n; i++) begin
					if (((mask >> i) & 1) == 0)
						continue;
					members++;
					for (j = i + 1; j < n; j++)
						if (((mask >> j) & 1) != 0 && !strict_overlap(set_rects[i], set_rects[j]))
							apart = 1;
					xi = longint'(set_rects[i].x);
					yi = longint'(set_rects[i].y);
					ri = xi + longint'(set_rects[i].w);
					bi = yi + longint'(set_rects[i].h);
					if (xi > left) left = xi;
					if (yi > top) top = yi;
					if (ri < right) right = ri;
					if (bi < bottom) bottom = bi;
				end
				if (!apart && right >= left && bottom >= top) begin
					term = (right - left) * (bottom - top);
					total += (members % 2 == 1) ? term : -term;
				end
			end
			return total;
		endfunction

		function void note_rect(rect_t r, bit last);
			longint       total;
			area_result_t res;
			if (set_rects.size() < MAX_RECTS)
				set_rects.insert(set_rects.size(), r);
			else
				dropped = 1;
			if (last) begin
				total = union_area_predict();
				res.area = (total < 0) ? '0 : total[AREA_W-1:0];
				res.too_many = dropped;
				areas_due.insert(areas_due.size(), res);
				set_rects.delete();
				dropped = 0;
			end
		endfunction

		function void check_result(logic [AREA_W-1:0] area, logic too_many);
			area_result_t exp;
			if (areas_due.size() == 0) begin
				$display("%0t: result with nothing due: union_area %0d too_many %0b",
					$time, area, too_many);
				errors++;
				return;
			end
			exp = areas_due.pop_front();
			if (area !== exp.area) begin
				$display("%0t: union_area mismatch: expected %0d actual %0d",
					$time, exp.area, area);
				errors++;
			end
			if (too_many !== exp.too_many) begin
				$display("%0t: too_many mismatch: expected %0b actual %0b",
					$time, exp.too_many, too_many);
				errors++;
			end
		endfunction

		function int pending();
			return areas_due.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rua_in_if  in_ch();
	rua_out_if out_ch();

	rect_union_area_incl_excl i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	area_scoreboard sb = new();

	int    rects_sent;
	int    burst_left;
	rect_t prev_rect;
	int    hold_off_reqs;
	int    hold_off_served;
	int    idle_cycles;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// receiver stall pattern, with long hold-offs on request
	initial begin
		rx_mode_e rx_mode;
		int       phase_left;
		int       hold_left;
		out_ch.ready = 0;
		rx_mode = RX_FREE;
		phase_left = 0;
		hold_left = 0;
		hold_off_served = 0;
		forever begin
			@(negedge clk);
			if (hold_off_reqs != hold_off_served) begin
				hold_off_served++;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (!arst_n || hold_left > 0) begin
				out_ch.ready = 0;
				if (hold_left > 0) hold_left--;
			end else begin
				if (phase_left == 0) begin
					rx_mode = rx_mode_e'($urandom_range(0, 3));
					phase_left = $urandom_range(10, 300);
				end
				phase_left--;
				case (rx_mode)
					RX_FREE:     out_ch.ready = 1;
					RX_RANDOM:   out_ch.ready = ($urandom_range(0, 1) == 1);
					RX_SPARSE:   out_ch.ready = ($urandom_range(0, 3) == 0);
					RX_PERIODIC: out_ch.ready = ((phase_left % 7) < 3);
					default:     out_ch.ready = 1;
				endcase
			end
		end
	end

	// result check
	initial begin
		forever begin
			@(posedge clk);
			if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
				sb.check_result(out_ch.union_area, out_ch.too_many);
		end
	end

	// watchdog on cycles without any transaction
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
				(out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, idle_cycles);
				$display("FAIL");
				$finish;
			end
		end
	end

	function automatic rect_t mk_rect(int x, int y, int w, int h);
		rect_t r;
		r.x = CRD_W'(x);
		r.y = CRD_W'(y);
		r.w = CRD_W'(w);
		r.h = CRD_W'(h);
		return r;
	endfunction

	function automatic int clip_crd(int v);
		return (v > CRD_MAX) ? CRD_MAX : v;
	endfunction

	// mostly clustered rectangles so that subsets overlap, some wild ones
	function automatic rect_t random_rect(int cx, int cy, rect_t prev);
		int    pick;
		rect_t r;
		pick = $urandom_range(0, 9);
		if (pick < 2) begin
			r = mk_rect($urandom_range(0, CRD_MAX), $urandom_range(0, CRD_MAX),
				$urandom_range(0, CRD_MAX), $urandom_range(0, CRD_MAX));
		end else if (pick == 9) begin
			// shares an edge with the previous rectangle
			r = mk_rect(clip_crd(int'(prev.x) + int'(prev.w)), int'(prev.y),
				$urandom_range(0, 64), $urandom_range(0, 64));
		end else begin
			r = mk_rect(clip_crd(cx + $urandom_range(0, 63)),
				clip_crd(cy + $urandom_range(0, 63)),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, CRD_MAX) : $urandom_range(0, 96),
				$urandom_range(0, 3) == 0 ? $urandom_range(0, CRD_MAX) : $urandom_range(0, 96));
			if (pick == 8) begin
				if ($urandom_range(0, 1)) r.w = '0;
				else r.h = '0;
			end
		end
		return r;
	endfunction

	task automatic idle_for(int n);
		repeat (n) begin
			@(negedge clk);
			in_ch.valid = 0;
		end
	endtask

	task automatic send_rect(rect_t r, bit last);
		if (burst_left == 0) begin
			idle_for($urandom_range(1, 6));
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
				: $urandom_range(1, 12);
		end
		burst_left--;
		@(negedge clk);
		in_ch.valid = 1;
		in_ch.rect_x = r.x;
		in_ch.rect_y = r.y;
		in_ch.rect_width = r.w;
		in_ch.rect_height = r.h;
		in_ch.last_rect = last;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		sb.note_rect(r, last);
		prev_rect = r;
		rects_sent++;
	endtask

	task automatic wait_drained();
		idle_for(1);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic send_random_set(int size_cap);
		int    roll, size, cx, cy, k;
		rect_t r;
		roll = $urandom_range(0, 99);
		if (roll < 45) size = $urandom_range(1, 3);
		else if (roll < 80) size = $urandom_range(4, 6);
		else if (roll < 92) size = $urandom_range(7, MAX_RECTS);
		else size = $urandom_range(MAX_RECTS + 1, MAX_RECTS + 4);
		if (size > size_cap) size = size_cap;
		cx = $urandom_range(0, CRD_MAX);
		cy = $urandom_range(0, CRD_MAX);
		for (k = 0; k < size; k++) begin
			r = random_rect(cx, cy, prev_rect);
			send_rect(r, k == size - 1);
		end
	endtask

	initial begin
		int set_no;
		int q;
		arst_n = 0;
		in_ch.valid = 0;
		in_ch.rect_x = '0;
		in_ch.rect_y = '0;
		in_ch.rect_width = '0;
		in_ch.rect_height = '0;
		in_ch.last_rect = 0;
		rects_sent = 0;
		burst_left = 0;
		prev_rect = '0;
		hold_off_reqs = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// largest single rectangle, then an empty one
		send_rect(mk_rect(CRD_MAX, CRD_MAX, CRD_MAX, CRD_MAX), 1);
		send_rect(mk_rect(0, 0, 0, 0), 1);
		// duplicates count as distinct members
		send_rect(mk_rect(10, 10, 5, 5), 0);
		send_rect(mk_rect(10, 10, 5, 5), 1);
		// touching edges do not overlap
		send_rect(mk_rect(0, 0, 10, 10), 0);
		send_rect(mk_rect(10, 0, 10, 10), 1);
		// zero width inside a larger rectangle
		send_rect(mk_rect(5, 5, 0, 10), 0);
		send_rect(mk_rect(0, 0, 20, 20), 1);
		// three mutually overlapping
		send_rect(mk_rect(0, 0, 4, 4), 0);
		send_rect(mk_rect(2, 2, 4, 4), 0);
		send_rect(mk_rect(1, 1, 4, 4), 1);
		// full store of quadrants covering the whole range, last one dropped
		for (q = 0; q < MAX_RECTS; q++)
			send_rect(mk_rect((q % 2) * CRD_MAX, ((q / 2) % 2) * CRD_MAX, CRD_MAX, CRD_MAX), 0);
		send_rect(mk_rect(500, 500, 1, 1), 1);
		wait_drained();

		set_no = 0;
		while (rects_sent < N_ITEMS) begin
			set_no++;
			if (set_no == 30 || set_no == 250) begin
				// receiver holds off while small sets keep coming
				hold_off_reqs++;
				repeat (12) send_random_set(2);
			end
			if (set_no % 60 == 0)
				wait_drained();
			send_random_set(MAX_RECTS + 4);
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

@@ sim.f @@
sv/rua_pkg.sv
sv/rua_in_if.sv
sv/rua_out_if.sv
sv/rua_store.sv
sv/rua_isect.sv
sv/rua_acc.sv
sv/rect_union_area_incl_excl.sv
sim/tb_rect_union_area_incl_excl.sv
